// ===== sv/dual_isa_instruction_class_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef DUAL_ISA_INSTRUCTION_CLASS_DECODER_ASSERT_SVH
`define DUAL_ISA_INSTRUCTION_CLASS_DECODER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DICD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define DICD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dicd_pkg.sv =====
package dicd_pkg;

  typedef enum logic [5:0] {
    W_BRANCH = 6'd0, W_BX = 6'd1, W_CDP = 6'd2, W_DP_IMM = 6'd3, W_DP_ISH = 6'd4,
    W_DP_RSH = 6'd5, W_SWAP = 6'd6, W_HALF_IMM = 6'd7, W_HALF_REG = 6'd8,
    W_LS_IMM = 6'd9, W_LS_MULT = 6'd10, W_LS_REG = 6'd11, W_SGN_IMM = 6'd12,
    W_SGN_REG = 6'd13, W_MCR = 6'd14, W_MRC = 6'd15, W_REG_MOVE = 6'd16,
    W_MRS = 6'd17, W_MSR_IMM = 6'd18, W_MSR_REG = 6'd19, W_MUL = 6'd20,
    W_MULL = 6'd21, W_SWI = 6'd22, W_UNDEF = 6'd23,
    C_ALU = 6'd24, C_ALU_EXT = 6'd25, C_ADD_PCSP = 6'd26, C_ADDSUB_IMM = 6'd27,
    C_ADDSUB_REG = 6'd28, C_ADJ_SP = 6'd29, C_BX = 6'd30, C_FAR_PRE = 6'd31,
    C_FAR_SUF = 6'd32, C_BRANCH = 6'd33, C_BCOND = 6'd34, C_IMM_OP = 6'd35,
    C_LIT_LOAD = 6'd36, C_BYTE_IMM = 6'd37, C_HALF_IMM = 6'd38, C_LS_MULT = 6'd39,
    C_REG_OFS = 6'd40, C_STACK_REL = 6'd41, C_WORD_IMM = 6'd42, C_SHIFT_IMM = 6'd43,
    C_SWI = 6'd44, C_PUSH_POP = 6'd45, C_UNDEF = 6'd46
  } class_e;

  localparam logic [3:0] CondAlways = 4'd14;

  localparam int unsigned FlSave = 0;
  localparam int unsigned FlWb   = 1;
  localparam int unsigned FlByte = 2;
  localparam int unsigned FlUp   = 3;
  localparam int unsigned FlPre  = 4;
  localparam int unsigned FlLink = 5;
  localparam int unsigned FlHalf = 6;
  localparam int unsigned FlSign = 7;

  typedef struct packed {
    class_e      instr_class;
    logic [3:0]  cond_code;
    logic [3:0]  reg_dest;
    logic [3:0]  reg_base;
    logic [3:0]  reg_second;
    logic [3:0]  reg_shift;
    logic [23:0] imm_value;
    logic [4:0]  shift_amount;
    logic [1:0]  shift_kind;
    logic [3:0]  op_select;
    logic [7:0]  flag_bits;
  } result_t;

endpackage

// ===== sv/dual_isa_instruction_class_decoder.sv =====
// Instruction class decoder for a dual instruction set core. Each transaction
// carries one instruction word and a set selector (mode_i = 0 for the 32-bit
// set, 1 for the 16-bit compact set, which uses only opcode_i[15:0]). The
// block returns one result transaction with the instruction class and the
// operand fields of that class; fields a class does not use are zero. The
// 32-bit set is classed on bits 27:20 and 7:4 only. An accepted input passes
// the input register and the decode logic into the result register, which
// raises result valid. One transaction is accepted per clock while the pipe
// advances: an input register feeds a single level of decode logic whose
// output lands in a result register, and both stages advance together
// whenever the result register is empty or being drained. Input stall is
// raised only while a valid result is held by a stalled receiver.
module dual_isa_instruction_class_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] opcode_i,
  input  logic        mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  instr_class_o,
  output logic [3:0]  cond_code_o,
  output logic [3:0]  reg_dest_o,
  output logic [3:0]  reg_base_o,
  output logic [3:0]  reg_second_o,
  output logic [3:0]  reg_shift_o,
  output logic [23:0] imm_value_o,
  output logic [4:0]  shift_amount_o,
  output logic [1:0]  shift_kind_o,
  output logic [3:0]  op_select_o,
  output logic [7:0]  flag_bits_o
);
  import dicd_pkg::*;

  // Two stage pipeline: input register, then result register.
  logic        in_vld_q, out_vld_q;
  logic [31:0] op_q;
  logic        mode_q;
  result_t     res_d, res_q;
  logic        adv;

  // The whole pipe moves when the result register can take new data.
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= in_valid_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q   <= opcode_i;
      mode_q <= mode_i;
      res_q  <= res_d;
    end
  end

  // Decode logic.
  always_comb begin
    logic [31:0] op;
    logic        tst;
    logic        save;
    logic [4:0]  t5;
    class_e      cls;
    op   = op_q;
    tst  = (op[24:23] == 2'b10) && !op[20];
    save = op[20];
    t5   = op[15:11];
    cls  = W_UNDEF;
    res_d = '0;
    if (!mode_q) begin
      case (op[27:25])
        3'd5: cls = W_BRANCH;
        3'd7: cls = op[24] ? W_SWI : (!op[4] ? W_CDP : (op[20] ? W_MRC : W_MCR));
        3'd6: cls = W_UNDEF;
        3'd4: cls = W_LS_MULT;
        3'd2: cls = W_LS_IMM;
        3'd3: cls = op[4] ? W_UNDEF : W_LS_REG;
        3'd1: cls = tst ? (op[21] ? W_MSR_IMM : W_REG_MOVE) : W_DP_IMM;
        default: begin
          if (!op[4])      cls = tst ? (op[21] ? W_MSR_REG : W_MRS) : W_DP_ISH;
          else if (!op[7]) cls = tst ? W_BX : W_DP_RSH;
          else begin
            case (op[6:5])
              2'd0:    cls = op[24] ? W_SWAP : (op[23] ? W_MULL : W_MUL);
              2'd1:    cls = op[22] ? W_HALF_IMM : W_HALF_REG;
              default: cls = op[22] ? W_SGN_IMM : W_SGN_REG;
            endcase
          end
        end
      endcase
      res_d.instr_class = cls;
      res_d.cond_code   = op[31:28];
      case (cls)
        W_BRANCH: begin
          res_d.imm_value = op[23:0];
          res_d.flag_bits[FlLink] = op[24];
        end
        W_BX: begin
          res_d.reg_second = op[3:0]; res_d.reg_dest = op[15:12];
          res_d.reg_base = op[19:16]; res_d.op_select = {3'b0, op[22]};
        end
        W_CDP, W_MCR, W_MRC: begin
          res_d.reg_second = op[3:0]; res_d.imm_value = {21'b0, op[7:5]};
          res_d.reg_shift = op[11:8]; res_d.reg_dest = op[15:12];
          res_d.reg_base = op[19:16];
          res_d.op_select = (cls == W_CDP) ? op[23:20] : {1'b0, op[23:21]};
        end
        W_DP_IMM: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.shift_amount = {1'b0, op[11:8]};
          res_d.reg_dest = op[15:12]; res_d.reg_base = op[19:16];
          res_d.flag_bits[FlSave] = save; res_d.op_select = op[24:21];
        end
        W_DP_ISH, W_DP_RSH: begin
          res_d.reg_second = op[3:0]; res_d.shift_kind = op[6:5];
          if (cls == W_DP_ISH) res_d.shift_amount = op[11:7];
          else res_d.reg_shift = op[11:8];
          res_d.reg_dest = op[15:12]; res_d.reg_base = op[19:16];
          res_d.flag_bits[FlSave] = save; res_d.op_select = op[24:21];
        end
        W_SWAP: begin
          res_d.reg_second = op[3:0]; res_d.reg_dest = op[15:12];
          res_d.reg_base = op[19:16]; res_d.flag_bits[FlByte] = op[22];
        end
        W_HALF_IMM, W_HALF_REG, W_SGN_IMM, W_SGN_REG, W_LS_IMM, W_LS_REG: begin
          if (cls == W_HALF_IMM || cls == W_SGN_IMM)
            res_d.imm_value = {16'b0, op[11:8], op[3:0]};
          else if (cls == W_LS_IMM) res_d.imm_value = {12'b0, op[11:0]};
          else res_d.reg_second = op[3:0];
          if (cls == W_LS_REG) begin
            res_d.shift_kind = op[6:5]; res_d.shift_amount = op[11:7];
          end
          res_d.reg_dest = op[15:12]; res_d.reg_base = op[19:16];
          res_d.op_select = {3'b0, op[20]};
          res_d.flag_bits[FlWb] = op[21]; res_d.flag_bits[FlUp] = op[23];
          res_d.flag_bits[FlPre] = op[24];
          res_d.flag_bits[FlByte] = (cls == W_LS_IMM || cls == W_LS_REG) && op[22];
          res_d.flag_bits[FlHalf] = (cls == W_SGN_IMM || cls == W_SGN_REG) && op[5];
        end
        W_LS_MULT: begin
          res_d.imm_value = {8'b0, op[15:0]}; res_d.reg_base = op[19:16];
          res_d.op_select = {2'b0, op[22], op[20]};
          res_d.flag_bits[FlWb] = op[21]; res_d.flag_bits[FlUp] = op[23];
          res_d.flag_bits[FlPre] = op[24];
        end
        W_REG_MOVE: begin
          res_d.reg_dest = op[15:12]; res_d.reg_base = op[19:16];
        end
        W_MRS: begin
          res_d.reg_dest = op[15:12]; res_d.op_select = {3'b0, op[22]};
        end
        W_MSR_IMM: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.shift_amount = {1'b0, op[11:8]};
          res_d.reg_base = op[19:16]; res_d.op_select = {3'b0, op[22]};
        end
        W_MSR_REG: begin
          res_d.reg_second = op[3:0]; res_d.shift_kind = op[6:5];
          res_d.shift_amount = op[11:7]; res_d.reg_base = op[19:16];
          res_d.op_select = {3'b0, op[22]};
        end
        W_MUL, W_MULL: begin
          res_d.reg_second = op[3:0]; res_d.reg_shift = op[11:8];
          res_d.reg_base = op[15:12]; res_d.reg_dest = op[19:16];
          res_d.op_select = {3'b0, op[21]};
          res_d.flag_bits[FlSave] = save;
          res_d.flag_bits[FlSign] = (cls == W_MULL) && op[22];
        end
        W_SWI: res_d.imm_value = op[23:0];
        default: ;
      endcase
    end else begin
      res_d.cond_code = CondAlways;
      case (op[15:13])
        3'd0: begin
          if (op[12:11] != 2'b11) cls = C_SHIFT_IMM;
          else cls = op[10] ? C_ADDSUB_IMM : C_ADDSUB_REG;
        end
        3'd1: cls = C_IMM_OP;
        3'd2: begin
          if (op[15:10] == 6'h10)      cls = C_ALU;
          else if (op[15:10] == 6'h11) cls = (op[9:8] == 2'b11) ? C_BX : C_ALU_EXT;
          else if (t5 == 5'h09)        cls = C_LIT_LOAD;
          else                         cls = C_REG_OFS;
        end
        3'd3: cls = op[12] ? C_BYTE_IMM : C_WORD_IMM;
        3'd4: cls = op[12] ? C_STACK_REL : C_HALF_IMM;
        3'd5: begin
          if (!op[12])                cls = C_ADD_PCSP;
          else if (op[11:8] == 4'd0)  cls = C_ADJ_SP;
          else if (op[10:9] == 2'b10) cls = C_PUSH_POP;
          else                        cls = C_UNDEF;
        end
        3'd6: begin
          if (!op[12])                cls = C_LS_MULT;
          else if (op[11:8] == 4'hf)  cls = C_SWI;
          else if (op[11:8] == 4'he)  cls = C_UNDEF;
          else                        cls = C_BCOND;
        end
        default: begin
          case (t5)
            5'h1c:   cls = C_BRANCH;
            5'h1d:   cls = C_UNDEF;
            5'h1e:   cls = C_FAR_PRE;
            default: cls = C_FAR_SUF;
          endcase
        end
      endcase
      res_d.instr_class = cls;
      case (cls)
        C_ALU: begin
          res_d.reg_dest = {1'b0, op[2:0]}; res_d.reg_second = {1'b0, op[5:3]};
          res_d.op_select = op[9:6];
        end
        C_ALU_EXT: begin
          res_d.reg_dest = {op[7], op[2:0]}; res_d.reg_second = op[6:3];
          res_d.op_select = {2'b0, op[9:8]};
        end
        C_ADD_PCSP, C_STACK_REL: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.reg_dest = {1'b0, op[10:8]};
          res_d.op_select = {3'b0, op[11]};
        end
        C_ADDSUB_IMM, C_ADDSUB_REG: begin
          res_d.reg_dest = {1'b0, op[2:0]}; res_d.reg_base = {1'b0, op[5:3]};
          if (cls == C_ADDSUB_IMM) res_d.imm_value = {21'b0, op[8:6]};
          else res_d.reg_second = {1'b0, op[8:6]};
          res_d.op_select = {3'b0, op[9]};
        end
        C_ADJ_SP: begin
          res_d.imm_value = {17'b0, op[6:0]}; res_d.op_select = {3'b0, op[7]};
        end
        C_BX: res_d.reg_second = op[6:3];
        C_FAR_PRE, C_FAR_SUF, C_BRANCH: res_d.imm_value = {13'b0, op[10:0]};
        C_BCOND: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.cond_code = op[11:8];
        end
        C_IMM_OP: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.reg_dest = {1'b0, op[10:8]};
          res_d.op_select = {2'b0, op[12:11]};
        end
        C_LIT_LOAD: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.reg_dest = {1'b0, op[10:8]};
        end
        C_BYTE_IMM, C_HALF_IMM, C_WORD_IMM: begin
          res_d.reg_dest = {1'b0, op[2:0]}; res_d.reg_base = {1'b0, op[5:3]};
          res_d.imm_value = {19'b0, op[10:6]}; res_d.op_select = {3'b0, op[11]};
        end
        C_LS_MULT: begin
          res_d.imm_value = {16'b0, op[7:0]}; res_d.reg_base = {1'b0, op[10:8]};
          res_d.op_select = {3'b0, op[11]};
        end
        C_REG_OFS: begin
          res_d.reg_dest = {1'b0, op[2:0]}; res_d.reg_base = {1'b0, op[5:3]};
          res_d.reg_second = {1'b0, op[8:6]}; res_d.op_select = {1'b0, op[11:9]};
        end
        C_SHIFT_IMM: begin
          res_d.reg_dest = {1'b0, op[2:0]}; res_d.reg_second = {1'b0, op[5:3]};
          res_d.shift_amount = op[10:6]; res_d.op_select = {2'b0, op[12:11]};
        end
        C_SWI: res_d.imm_value = {16'b0, op[7:0]};
        C_PUSH_POP: begin
          res_d.imm_value = {15'b0, op[8:0]}; res_d.op_select = {3'b0, op[11]};
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign instr_class_o  = res_q.instr_class;
  assign cond_code_o    = res_q.cond_code;
  assign reg_dest_o     = res_q.reg_dest;
  assign reg_base_o     = res_q.reg_base;
  assign reg_second_o   = res_q.reg_second;
  assign reg_shift_o    = res_q.reg_shift;
  assign imm_value_o    = res_q.imm_value;
  assign shift_amount_o = res_q.shift_amount;
  assign shift_kind_o   = res_q.shift_kind;
  assign op_select_o    = res_q.op_select;
  assign flag_bits_o    = res_q.flag_bits;

`include "dual_isa_instruction_class_decoder_assert.svh"

  `DICD_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o, out_vld_q && out_stall_i,
    "input stalled while result register free")
  `DICD_ASSERT_NEXT(a_item_reaches_output, clk_i, rst_ni,
    in_vld_q && adv, out_vld_q,
    "decoded item lost between stages")
  `DICD_ASSERT_NEXT(a_result_holds, clk_i, rst_ni,
    out_vld_q && out_stall_i, out_vld_q && $stable(res_q),
    "stalled result changed")
  `DICD_ASSERT_IMP(a_compact_class_range, clk_i, rst_ni,
    out_vld_q && $past(mode_q && adv), res_q.instr_class >= C_ALU,
    "compact item gave a wide class")

endmodule
